[sv/bflt_pkg.sv]
// Types and constants shared by the bilateral filter stream block.
package bflt_pkg;

    // Input word operation codes
    typedef enum logic [1:0] {
        FUNC_PIXEL      = 2'd0,
        FUNC_FLUSH      = 2'd1,
        FUNC_LOAD_COLOR = 2'd2,
        FUNC_LOAD_SPACE = 2'd3
    } t_func;

    // Configuration register indexes
    localparam logic [1:0] CFG_IMAGE_WIDTH   = 2'd0;
    localparam logic [1:0] CFG_IMAGE_HEIGHT  = 2'd1;
    localparam logic [1:0] CFG_WINDOW_RADIUS = 2'd2;
    localparam logic [1:0] CFG_COLOR_MODE    = 2'd3;

    localparam int CFG_DATA_W = 13;
    localparam int MAX_HEIGHT = 4096;

    typedef struct packed {
        t_func       func;
        logic [7:0]  pixel_ch0;
        logic [7:0]  pixel_ch1;
        logic [7:0]  pixel_ch2;
        logic [9:0]  table_index;
        logic [15:0] table_value;
    } t_in;

    typedef struct packed {
        logic [7:0]  out_ch0;
        logic [7:0]  out_ch1;
        logic [7:0]  out_ch2;
        logic [11:0] out_row;
        logic [9:0]  out_col;
        logic        frame_last;
    } t_out;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_CENTER,
        ST_CWAIT,
        ST_TAPS,
        ST_DRAIN,
        ST_DIV_LOAD,
        ST_DIV_STEP,
        ST_DIV_RND,
        ST_OUT
    } t_state;

endpackage

[sv/bflt_ram.sv]
// Generic simple dual-port RAM with registered read data.
module bflt_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

[sv/bilateral_filter_stream.sv]
// Bilateral filter stream: top level with tap walk sequencer and shared divider.
// Table loads finish in IDLE; pixel and flush words add a pass through the result check state.
// A result passes CHECK, CENTER, CWAIT, the (2r+1)^2 taps, the pipeline drain and the output
// state, plus the divider per channel (load, range check, eight restoring steps, rounding).
// A colour result divides three channels and a gray result one; an output stall holds it in OUT.
// Reset (synchronous, active low) clears positions and restores default registers;
// the line store and weight tables keep their contents and hold nothing valid.
module bilateral_filter_stream #(
    parameter int MAX_WIDTH         = 1024,
    parameter int MAX_RADIUS        = 3,
    parameter int COLOR_TABLE_DEPTH = 768
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  bflt_pkg::t_in                      i_in_data,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output bflt_pkg::t_out                     o_out_data,
    input  logic                               i_cfg_we,
    input  logic [1:0]                         i_cfg_index,
    input  logic [bflt_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    import bflt_pkg::*;

    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int LR    = 1 << $clog2(2 * MAX_RADIUS + 2);
    localparam int LRW   = $clog2(LR);
    localparam int AW    = $clog2(LR * MAX_WIDTH);
    localparam int TS    = 2 * MAX_RADIUS + 1;
    localparam int TAPN  = TS * TS;
    localparam int TAPW  = $clog2(TAPN);
    localparam int CTW   = $clog2(COLOR_TABLE_DEPTH);
    localparam int WSW   = 32 + $clog2(TAPN + 1);
    localparam int SUMW  = WSW + 8;

    // Fold an index onto 0..n-1 by repeated mirroring, edge pixel repeated;
    // the index lies within three of the frame, so three folds cover a one pixel frame
    function automatic logic [12:0] f_mirror(input logic signed [14:0] idx,
                                             input logic [13:0] n);
        logic signed [15:0] p;
        logic signed [15:0] sn;
        p  = {idx[14], idx};
        sn = $signed({2'b00, n});
        for (int i = 0; i < 3; i++) begin
            if (p < 0) begin
                p = -16'sd1 - p;
            end else if (p >= sn) begin
                p = (sn <<< 1) - 16'sd1 - p;
            end
        end
        return p[12:0];
    endfunction

    function automatic logic [AW-1:0] f_ls_addr(input logic [11:0] row,
                                                input logic [CW-1:0] col);
        return AW'(row[LRW-1:0]) * AW'(MAX_WIDTH) + AW'(col);
    endfunction

    function automatic logic [8:0] f_absd(input logic [7:0] a, input logic [7:0] b);
        return (a > b) ? {1'b0, a - b} : {1'b0, b - a};
    endfunction

    // Configuration and position registers
    t_state            r_state, n_state;
    logic [10:0]       r_img_w;
    logic [12:0]       r_img_h;
    logic [1:0]        r_rad_cfg;
    logic              r_cmode;
    logic [11:0]       r_in_row, r_out_row;
    logic [CW-1:0]     r_in_col, r_out_col;
    logic              r_in_done;

    // Tap walk and pipeline
    logic signed [4:0] r_dy, r_dx;
    logic              r_p1_v, r_p2_v, r_p3_v, r_p4_v;
    logic [11:0]       r_p1_row;
    logic [CW-1:0]     r_p1_col;
    logic [TAPW-1:0]   r_p1_tap;
    logic [23:0]       r_p3_px, r_p4_px;
    logic [15:0]       r_p3_sw;
    logic [31:0]       r_p4_w;
    logic [23:0]       r_center;
    logic [SUMW-1:0]   r_sum [3];
    logic [WSW-1:0]    r_wsum;

    // Divider
    logic [1:0]        r_ch;
    logic [3:0]        r_k;
    logic [SUMW-1:0]   r_rem;
    logic [7:0]        r_q;
    logic [7:0]        r_res [3];

    logic              r_out_valid;
    t_out              r_out;

    // Effective frame settings
    logic [13:0]       w_W, w_H;
    logic [3:0]        w_rad;
    logic signed [4:0] w_rad_s;
    always_comb begin
        w_W = (r_img_w == 11'd0) ? 14'd1 :
              ({3'b000, r_img_w} > 14'(MAX_WIDTH)) ? 14'(MAX_WIDTH) : {3'b000, r_img_w};
        w_H = (r_img_h == 13'd0) ? 14'd1 :
              ({1'b0, r_img_h} > 14'(MAX_HEIGHT)) ? 14'(MAX_HEIGHT) : {1'b0, r_img_h};
        w_rad = ({2'b00, r_rad_cfg} > 4'(MAX_RADIUS)) ? 4'(MAX_RADIUS) : {2'b00, r_rad_cfg};
        w_rad_s = $signed({1'b0, w_rad});
    end

    logic w_acc, w_chk;
    assign o_in_ready = (r_state == ST_IDLE);
    assign w_acc      = i_in_valid && o_in_ready;
    // Only pixel and flush words can release a result
    assign w_chk      = w_acc && (i_in_data.func inside {FUNC_PIXEL, FUNC_FLUSH});

    // Result readiness against the window's last needed pixel
    logic [13:0] w_nr, w_nc;
    logic        w_res_ready;
    always_comb begin
        w_nr = {2'b00, r_out_row} + 14'(w_rad);
        w_nc = 14'(r_out_col) + 14'(w_rad);
        if (w_nr > w_H - 14'd1) w_nr = w_H - 14'd1;
        if (w_nc > w_W - 14'd1) w_nc = w_W - 14'd1;
        w_res_ready = r_in_done || (w_nr < {2'b00, r_in_row}) ||
                      ((w_nr == {2'b00, r_in_row}) && (w_nc < 14'(r_in_col)));
    end

    // Memories
    logic              w_ls_we, w_cw_we, w_sp_we;
    logic [AW-1:0]     w_ls_raddr;
    logic [23:0]       w_ls_rdata;
    logic [CTW-1:0]    w_cw_raddr;
    logic [15:0]       w_cw_rdata, w_sp_rdata;

    assign w_ls_we = w_acc && (i_in_data.func == FUNC_PIXEL);
    assign w_cw_we = w_acc && (i_in_data.func == FUNC_LOAD_COLOR) &&
                     (i_in_data.table_index < 10'(COLOR_TABLE_DEPTH));
    assign w_sp_we = w_acc && (i_in_data.func == FUNC_LOAD_SPACE) &&
                     ({1'b0, i_in_data.table_index} < 11'(TAPN));
    assign w_ls_raddr = (r_state == ST_CENTER) ? f_ls_addr(r_out_row, r_out_col)
                                               : f_ls_addr(r_p1_row, r_p1_col);

    bflt_ram #(.WIDTH(24), .DEPTH(LR * MAX_WIDTH)) u_line_store (
        .i_clk   (i_clk),
        .i_we    (w_ls_we),
        .i_waddr (f_ls_addr(r_in_row, r_in_col)),
        .i_wdata ({i_in_data.pixel_ch2, i_in_data.pixel_ch1, i_in_data.pixel_ch0}),
        .i_raddr (w_ls_raddr),
        .o_rdata (w_ls_rdata)
    );

    bflt_ram #(.WIDTH(16), .DEPTH(COLOR_TABLE_DEPTH)) u_color_tbl (
        .i_clk   (i_clk),
        .i_we    (w_cw_we),
        .i_waddr (CTW'(i_in_data.table_index)),
        .i_wdata (i_in_data.table_value),
        .i_raddr (w_cw_raddr),
        .o_rdata (w_cw_rdata)
    );

    bflt_ram #(.WIDTH(16), .DEPTH(TAPN)) u_space_tbl (
        .i_clk   (i_clk),
        .i_we    (w_sp_we),
        .i_waddr (TAPW'(i_in_data.table_index)),
        .i_wdata (i_in_data.table_value),
        .i_raddr (r_p1_tap),
        .o_rdata (w_sp_rdata)
    );

    // Colour difference of the tap just read, clamped to the table
    logic [9:0] w_d;
    always_comb begin
        w_d = 10'(f_absd(w_ls_rdata[7:0], r_center[7:0]));
        if (r_cmode) begin
            w_d = w_d + 10'(f_absd(w_ls_rdata[15:8], r_center[15:8]))
                      + 10'(f_absd(w_ls_rdata[23:16], r_center[23:16]));
        end
        if (w_d >= 10'(COLOR_TABLE_DEPTH)) w_d = 10'(COLOR_TABLE_DEPTH - 1);
        w_cw_raddr = CTW'(w_d);
    end

    // Tap walk helpers
    logic w_tap_last, w_drained;
    logic signed [14:0] w_mr, w_mc;
    logic [12:0] w_mrow, w_mcol;
    assign w_tap_last = (r_dy == w_rad_s) && (r_dx == w_rad_s);
    assign w_drained  = !(r_p1_v || r_p2_v || r_p3_v || r_p4_v);
    assign w_mr = $signed({3'b000, r_out_row}) + 15'(r_dy);
    assign w_mc = $signed(15'(r_out_col)) + 15'(r_dx);
    assign w_mrow = f_mirror(w_mr, w_H);
    assign w_mcol = f_mirror(w_mc, w_W);

    // Divider step compare and rounding
    logic [SUMW-1:0] w_dv;
    logic            w_ge, w_last_ch, w_up;
    logic [SUMW:0]   w_twor;
    assign w_dv      = SUMW'(r_wsum) << r_k;
    assign w_ge      = (r_rem >= w_dv);
    assign w_last_ch = (r_ch == (r_cmode ? 2'd2 : 2'd0));
    assign w_twor    = {r_rem, 1'b0};
    assign w_up      = (w_twor > (SUMW + 1)'(r_wsum)) ||
                       ((w_twor == (SUMW + 1)'(r_wsum)) && r_q[0]);

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:     if (w_chk) n_state = ST_CHECK;
            ST_CHECK:    n_state = w_res_ready ? ST_CENTER : ST_IDLE;
            ST_CENTER:   n_state = ST_CWAIT;
            ST_CWAIT:    n_state = ST_TAPS;
            ST_TAPS:     if (w_tap_last) n_state = ST_DRAIN;
            ST_DRAIN:    if (w_drained) n_state = ST_DIV_LOAD;
            ST_DIV_LOAD: begin
                if (r_wsum == '0) n_state = w_last_ch ? ST_OUT : ST_DIV_LOAD;
                else n_state = ST_DIV_STEP;
            end
            ST_DIV_STEP: begin
                if (r_k == 4'd8 && w_ge) n_state = w_last_ch ? ST_OUT : ST_DIV_LOAD;
                else if (r_k == 4'd0) n_state = ST_DIV_RND;
            end
            ST_DIV_RND:  n_state = w_last_ch ? ST_OUT : ST_DIV_LOAD;
            ST_OUT:      if (!r_out_valid || i_out_ready) n_state = ST_IDLE;
            default:     n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Control: configuration, positions, pipeline valids, output word
    logic [13:0] w_in_col1, w_in_row1, w_out_col1, w_out_row1;
    logic        w_load_out;
    assign w_in_col1  = 14'(r_in_col) + 14'd1;
    assign w_in_row1  = {2'b00, r_in_row} + 14'd1;
    assign w_out_col1 = 14'(r_out_col) + 14'd1;
    assign w_out_row1 = {2'b00, r_out_row} + 14'd1;
    assign w_load_out = (r_state == ST_OUT) && (!r_out_valid || i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_img_w     <= 11'd1024;
            r_img_h     <= 13'd1024;
            r_rad_cfg   <= 2'd1;
            r_cmode     <= 1'b0;
            r_in_row    <= '0;
            r_in_col    <= '0;
            r_out_row   <= '0;
            r_out_col   <= '0;
            r_in_done   <= 1'b0;
            r_p1_v      <= 1'b0;
            r_p2_v      <= 1'b0;
            r_p3_v      <= 1'b0;
            r_p4_v      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_p1_v <= (r_state == ST_TAPS);
            r_p2_v <= r_p1_v;
            r_p3_v <= r_p2_v;
            r_p4_v <= r_p3_v;

            // Drop the output word once taken, load a fresh one
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            // Store position of an incoming pixel; a new frame abandons pending results
            if (w_acc && i_in_data.func == FUNC_PIXEL) begin
                if (r_in_done) begin
                    r_out_row <= '0;
                    r_out_col <= '0;
                    r_in_done <= 1'b0;
                end
                if (w_in_col1 >= w_W) begin
                    r_in_col <= '0;
                    if (w_in_row1 >= w_H) begin
                        r_in_row  <= '0;
                        r_in_done <= 1'b1;
                    end else begin
                        r_in_row <= w_in_row1[11:0];
                    end
                end else begin
                    r_in_col <= w_in_col1[CW-1:0];
                end
            end

            // Advance the output position with each result
            if (w_load_out) begin
                if (w_out_col1 >= w_W) begin
                    r_out_col <= '0;
                    if (w_out_row1 >= w_H) begin
                        r_out_row <= '0;
                        r_in_done <= 1'b0;
                    end else begin
                        r_out_row <= w_out_row1[11:0];
                    end
                end else begin
                    r_out_col <= w_out_col1[CW-1:0];
                end
            end

            // Register write restarts the frame
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_IMAGE_WIDTH:   r_img_w   <= i_cfg_data[10:0];
                    CFG_IMAGE_HEIGHT:  r_img_h   <= i_cfg_data[12:0];
                    CFG_WINDOW_RADIUS: r_rad_cfg <= i_cfg_data[1:0];
                    CFG_COLOR_MODE:    r_cmode   <= i_cfg_data[0];
                    default:           r_cmode   <= r_cmode;
                endcase
                r_in_row  <= '0;
                r_in_col  <= '0;
                r_out_row <= '0;
                r_out_col <= '0;
                r_in_done <= 1'b0;
            end
        end
    end

    // Datapath: tap walk, weight pipeline, accumulators, divider
    always_ff @(posedge i_clk) begin
        // Walk the window one tap a cycle
        if (r_state == ST_CWAIT) begin
            r_dy <= -w_rad_s;
            r_dx <= -w_rad_s;
        end else if (r_state == ST_TAPS) begin
            if (r_dx == w_rad_s) begin
                r_dx <= -w_rad_s;
                r_dy <= r_dy + 5'sd1;
            end else begin
                r_dx <= r_dx + 5'sd1;
            end
        end
        r_p1_row <= w_mrow[11:0];
        r_p1_col <= CW'(w_mcol);
        r_p1_tap <= TAPW'((int'(r_dy) + MAX_RADIUS) * TS + int'(r_dx) + MAX_RADIUS);

        if (r_state == ST_CWAIT) r_center <= w_ls_rdata;

        r_p3_px <= w_ls_rdata;
        r_p3_sw <= w_sp_rdata;
        r_p4_px <= r_p3_px;
        r_p4_w  <= r_p3_sw * w_cw_rdata;

        // Accumulate weighted channels and weight sum
        if (r_state == ST_CWAIT) begin
            for (int c = 0; c < 3; c++) r_sum[c] <= '0;
            r_wsum <= '0;
        end else if (r_p4_v) begin
            for (int c = 0; c < 3; c++) begin
                r_sum[c] <= r_sum[c] + SUMW'(r_p4_px[8*c +: 8]) * SUMW'(r_p4_w);
            end
            r_wsum <= r_wsum + WSW'(r_p4_w);
        end

        // Shared restoring divider, one quotient bit a cycle
        case (r_state)
            ST_DRAIN: r_ch <= 2'd0;
            ST_DIV_LOAD: begin
                if (r_wsum == '0) begin
                    r_res[r_ch] <= r_center[8*r_ch +: 8];
                    r_ch        <= r_ch + 2'd1;
                end else begin
                    r_rem <= r_sum[r_ch];
                    r_k   <= 4'd8;
                    r_q   <= '0;
                end
            end
            ST_DIV_STEP: begin
                if (r_k == 4'd8) begin
                    if (w_ge) begin
                        r_res[r_ch] <= 8'd255;
                        r_ch        <= r_ch + 2'd1;
                    end
                end else if (w_ge) begin
                    r_rem         <= r_rem - w_dv;
                    r_q[r_k[2:0]] <= 1'b1;
                end
                r_k <= r_k - 4'd1;
            end
            ST_DIV_RND: begin
                r_res[r_ch] <= (w_up && r_q != 8'd255) ? r_q + 8'd1 : r_q;
                r_ch        <= r_ch + 2'd1;
            end
            default: r_ch <= r_ch;
        endcase

        // Hold the result word until taken
        if (w_load_out) begin
            r_out.out_ch0    <= r_res[0];
            r_out.out_ch1    <= r_cmode ? r_res[1] : 8'd0;
            r_out.out_ch2    <= r_cmode ? r_res[2] : 8'd0;
            r_out.out_row    <= r_out_row;
            r_out.out_col    <= 10'(r_out_col);
            r_out.frame_last <= ({2'b00, r_out_row} == w_H - 14'd1) &&
                                (14'(r_out_col) == w_W - 14'd1);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Checks
    a_accept_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_chk |=> r_state == ST_CHECK)
        else $error("accepted word did not enter result check");
    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_DIV_STEP |-> r_wsum != '0)
        else $error("divider running on zero weight sum");
    a_rem_below: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_DIV_RND |-> r_rem < SUMW'(r_wsum))
        else $error("remainder not below divisor at rounding");
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state) == ST_OUT)
        else $error("result word raised outside output state");
    a_drain_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_DIV_LOAD |-> !r_p4_v)
        else $error("tap pipeline still busy at division");

endmodule
